>>> hdl/pms_pkg.sv
// Shared types and constants for the polarity misfit scorer.
package pms_pkg;

  localparam int TERMS      = 6;
  localparam int COEF_W     = 32;
  localparam int WEIGHT_W   = 16;
  localparam int IDX_W      = 8;
  localparam int SCORE_W    = 32;
  localparam int MIS_W      = 24;
  localparam int QUO_W      = 32;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int NUM_OBS_W  = 9;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam logic [SCORE_W-1:0]   ONE_Q29       = 32'd536870912;
  localparam logic [NUM_OBS_W-1:0] NUM_OBS_RESET = 9'd1;
  localparam logic [MIS_W-1:0]     MIS_MAX       = 24'hFFFFFF;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic REG_NUM_OBS = 1'b0;

  typedef logic [TERMS-1:0][COEF_W-1:0] coef_vec_t;

  typedef struct packed {
    logic                     func;
    logic [IDX_W-1:0]         obs_index;
    logic signed [COEF_W-1:0] coef_0;
    logic signed [COEF_W-1:0] coef_1;
    logic signed [COEF_W-1:0] coef_2;
    logic signed [COEF_W-1:0] coef_3;
    logic signed [COEF_W-1:0] coef_4;
    logic signed [COEF_W-1:0] coef_5;
    logic                     obs_polarity;
    logic [WEIGHT_W-1:0]      obs_weight;
  } in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [MIS_W-1:0]          mismatch_weight;
  } out_t;

  typedef struct packed {
    logic                polarity;
    logic [WEIGHT_W-1:0] weight;
    coef_vec_t           coef;
  } row_t;

  typedef struct packed {
    logic                valid;
    logic                miss;
    logic [WEIGHT_W-1:0] weight;
  } lane_res_t;

endpackage

>>> hdl/pms_obs_mem.sv
// Observation memory: one row per slot with coefficients, polarity and weight.
module pms_obs_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  pms_pkg::row_t   wr_row,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output pms_pkg::row_t   rd_row,
  output logic            rd_valid
);

  pms_pkg::row_t mem [DEPTH];
  pms_pkg::row_t rd_row_r;
  logic          rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_row   = rd_row_r;
  assign rd_valid = rd_valid_r;

endmodule

>>> hdl/pms_dot_sign.sv
// Pipelined six-term dot product with sign test against the observed polarity.
module pms_dot_sign (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  pms_pkg::row_t        row,
  input  pms_pkg::coef_vec_t   tensor,
  output pms_pkg::lane_res_t   res,
  output logic                 busy
);

  localparam int P = pms_pkg::PROD_W;

  logic signed [P-1:0]   prod_r [pms_pkg::TERMS];
  logic signed [P:0]     pair_r [3];
  logic signed [P+1:0]   quad_r;
  logic signed [P:0]     last_r;
  logic                  pol1_r, pol2_r, pol3_r;
  logic [pms_pkg::WEIGHT_W-1:0] w1_r, w2_r, w3_r;
  logic                  v1_r, v2_r, v3_r;
  logic                  miss_r;
  logic [pms_pkg::WEIGHT_W-1:0] w4_r;
  logic                  res_vld_r;
  logic signed [P+2:0]   sum;

  always_ff @(posedge clk) begin
    for (int t = 0; t < pms_pkg::TERMS; t++) begin
      prod_r[t] <= $signed(row.coef[t]) * $signed(tensor[t]);
    end
    pol1_r <= row.polarity;
    w1_r   <= row.weight;
    for (int k = 0; k < 3; k++) begin
      pair_r[k] <= {prod_r[2*k][P-1], prod_r[2*k]} + {prod_r[2*k+1][P-1], prod_r[2*k+1]};
    end
    pol2_r <= pol1_r;
    w2_r   <= w1_r;
    quad_r <= {pair_r[0][P], pair_r[0]} + {pair_r[1][P], pair_r[1]};
    last_r <= pair_r[2];
    pol3_r <= pol2_r;
    w3_r   <= w2_r;
    miss_r <= (sum[P+2] == pol3_r);
    w4_r   <= w3_r;
  end

  assign sum = {quad_r[P+1], quad_r} + {{2{last_r[P]}}, last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      res_vld_r <= v3_r;
    end
  end

  assign res  = '{valid: res_vld_r, miss: miss_r, weight: w4_r};
  assign busy = v1_r | v2_r | v3_r | res_vld_r;

endmodule

>>> hdl/pms_div.sv
// Serial restoring divider, one quotient bit per cycle.
module pms_div #(
  parameter int SUM_W = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SUM_W-1:0]          num_hi,
  input  logic [pms_pkg::QUO_W-1:0] num_lo,
  input  logic [SUM_W-1:0]          den,
  output logic                      busy,
  output logic [pms_pkg::QUO_W-1:0] quo
);

  localparam int QW = pms_pkg::QUO_W;

  logic [SUM_W-1:0]          rem_r, rem_nxt;
  logic [SUM_W-1:0]          den_r;
  logic [QW-1:0]             quo_r, quo_nxt;
  logic [pms_pkg::STEP_W-1:0] step_r;
  logic                      busy_r;
  logic [SUM_W:0]            trial;
  logic [SUM_W:0]            diff;
  logic                      ge;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    quo_nxt = {quo_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_hi;
      quo_r <= num_lo;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == pms_pkg::STEP_W'(QW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

>>> hdl/polarity_misfit_scorer.sv
// Top level of the polarity misfit scorer: control, configuration and result register.
// A load beat writes one observation row if its index is below MAX_OBS. An evaluate beat keeps
// in_ready low until it is done: the observation memory is read one row per cycle into a
// four-stage dot-product and sign pipeline, then a 32-step serial divider forms the score.
// With a zero total weight the divider is skipped. A new beat is taken once the previous
// evaluation has moved its result into the output register, even while that result still
// waits to be taken. Stored rows must be loaded before an evaluation reads them; there is no
// clearing pass after reset.
module polarity_misfit_scorer #(
  parameter int MAX_OBS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pms_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pms_pkg::out_t                   out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pms_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [pms_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [pms_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  localparam int AW    = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
  localparam int CNT_W = $clog2(MAX_OBS + 1);
  localparam int SUM_W = pms_pkg::WEIGHT_W + $clog2(MAX_OBS);
  localparam int NUM_W = SUM_W + pms_pkg::QUO_W;
  localparam int QW    = pms_pkg::QUO_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pms_pkg::NUM_OBS_W-1:0]   num_obs_r;
  pms_pkg::coef_vec_t              tensor_r;
  pms_pkg::coef_vec_t              in_coef;
  logic [CNT_W-1:0]                cnt_r, n_r;
  logic [SUM_W-1:0]                total_r, mis_r;
  logic                            out_valid_r;
  pms_pkg::out_t                   out_data_r;

  logic                            in_fire;
  logic                            cfg_wr;
  logic [31:0]                     n32;
  logic [31:0]                     idx32;
  logic                            wr_en;
  pms_pkg::row_t                   wr_row;
  logic                            rd_en;
  pms_pkg::row_t                   rd_row;
  logic                            rd_valid;
  pms_pkg::lane_res_t              res;
  logic                            dot_busy;
  logic                            div_start;
  logic                            div_busy;
  logic [QW-1:0]                   div_quo;
  logic [NUM_W-1:0]                num;
  logic [QW-1:0]                   q;
  logic [31:0]                     mis32;
  logic                            load_out;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign in_coef[0] = in_data.coef_0;
  assign in_coef[1] = in_data.coef_1;
  assign in_coef[2] = in_data.coef_2;
  assign in_coef[3] = in_data.coef_3;
  assign in_coef[4] = in_data.coef_4;
  assign in_coef[5] = in_data.coef_5;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == pms_pkg::REG_NUM_OBS) ?
                      pms_pkg::DATA_W'(num_obs_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_obs_r <= pms_pkg::NUM_OBS_RESET;
    end else if (cfg_wr && cfg_paddr[2] == pms_pkg::REG_NUM_OBS) begin
      num_obs_r <= cfg_pwdata[pms_pkg::NUM_OBS_W-1:0];
    end
  end

  assign n32 = (32'(num_obs_r) > 32'(MAX_OBS)) ? 32'(MAX_OBS) : 32'(num_obs_r);

  assign idx32         = 32'(in_data.obs_index);
  assign wr_en         = in_fire && in_data.func == pms_pkg::FUNC_LOAD && idx32 < 32'(MAX_OBS);
  assign wr_row.polarity = in_data.obs_polarity;
  assign wr_row.weight   = in_data.obs_weight;
  assign wr_row.coef     = in_coef;

  assign rd_en = (state_r == ST_RUN) && (cnt_r != n_r);

  pms_obs_mem #(
    .DEPTH (MAX_OBS),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (idx32[AW-1:0]),
    .wr_row   (wr_row),
    .rd_en    (rd_en),
    .rd_addr  (cnt_r[AW-1:0]),
    .rd_row   (rd_row),
    .rd_valid (rd_valid)
  );

  pms_dot_sign u_dot (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_valid),
    .row    (rd_row),
    .tensor (tensor_r),
    .res    (res),
    .busy   (dot_busy)
  );

  assign num = NUM_W'({mis_r, 31'b0}) + NUM_W'(total_r) - NUM_W'(1);

  pms_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (num[NUM_W-1:QW]),
    .num_lo (num[QW-1:0]),
    .den    (total_r),
    .busy   (div_busy),
    .quo    (div_quo)
  );

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.func == pms_pkg::FUNC_EVAL) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == n_r && !rd_valid && !dot_busy) begin
          if (total_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      total_r <= '0;
      mis_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_data.func == pms_pkg::FUNC_EVAL) begin
        cnt_r   <= '0;
        n_r     <= n32[CNT_W-1:0];
        total_r <= '0;
        mis_r   <= '0;
      end else begin
        if (rd_en) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (res.valid) begin
          total_r <= total_r + SUM_W'(res.weight);
          if (res.miss) begin
            mis_r <= mis_r + SUM_W'(res.weight);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.func == pms_pkg::FUNC_EVAL) begin
      tensor_r <= in_coef;
    end
  end

  assign q     = (total_r == '0) ? '0 : div_quo;
  assign mis32 = 32'(mis_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.score           <= pms_pkg::ONE_Q29 - q;
      out_data_r.mismatch_weight <= (mis32 > 32'(pms_pkg::MIS_MAX)) ?
                                    pms_pkg::MIS_MAX : mis32[pms_pkg::MIS_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
